>>> hw/rtl/kdhd_pkg.sv
// Shared types, codes and helpers for the key debounce and hold detector.
package kdhd_pkg;

  localparam int unsigned NUM_KEYS_DEF = 4;
  localparam int unsigned PIN_W        = 4;
  localparam int unsigned KIDX_W       = 3;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = CNT_W'(5);
  localparam logic [CNT_W-1:0] HOLD_RST     = CNT_W'(100);

  typedef enum logic [2:0] {
    ACT_SCAN    = 3'd0,
    ACT_TEST    = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_CLR_KEY = 3'd3,
    ACT_CLR_ALL = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRESSED   = 3'd1,
    PH_CONFIRMED = 3'd2,
    PH_HOLD      = 3'd3,
    PH_RELEASED  = 3'd4
  } key_phase_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_CLICK   = 2'd1,
    EV_HOLD    = 2'd2,
    EV_RELEASE = 2'd3
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_HOLD     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    event_e evt;
    logic   pressed_next;
  } lane_status_t;

  typedef struct packed {
    logic tick;
    logic clear;
  } lane_cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

endpackage

>>> hw/rtl/kdhd_lane.sv
// Per-key debounce and hold state machine with its latched event.
module kdhd_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kdhd_pkg::lane_cmd_t   cmd_i,
  input  logic                  down_i,
  input  logic [15:0]           debounce_ticks_i,
  input  logic [15:0]           hold_ticks_i,
  output kdhd_pkg::lane_status_t status_o
);
  import kdhd_pkg::*;

  key_phase_e       phase_q, phase_d;
  logic [CNT_W-1:0] deb_q, deb_d;
  logic [CNT_W-1:0] hold_q, hold_d;
  event_e           evt_q, evt_d;
  logic             pressed_q, pressed_d;
  logic [CNT_W-1:0] deb_inc, hold_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      deb_q     <= '0;
      hold_q    <= '0;
      evt_q     <= EV_NONE;
      pressed_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      deb_q     <= deb_d;
      hold_q    <= hold_d;
      evt_q     <= evt_d;
      pressed_q <= pressed_d;
    end
  end

  always_comb begin
    deb_inc   = sat_inc(deb_q);
    hold_inc  = sat_inc(hold_q);
    phase_d   = phase_q;
    deb_d     = deb_q;
    hold_d    = hold_q;
    evt_d     = evt_q;
    pressed_d = pressed_q;
    if (cmd_i.tick) begin
      unique case (phase_q)
        PH_PRESSED: begin
          if (down_i) begin
            deb_d = deb_inc;
            if (deb_inc >= debounce_ticks_i) begin
              phase_d   = PH_CONFIRMED;
              pressed_d = 1'b1;
              hold_d    = '0;
              evt_d     = EV_CLICK;
            end
          end else begin
            phase_d = PH_IDLE;
            deb_d   = '0;
          end
        end
        PH_CONFIRMED: begin
          if (down_i) begin
            hold_d = hold_inc;
            if (hold_inc >= hold_ticks_i) begin
              phase_d = PH_HOLD;
              evt_d   = EV_HOLD;
            end
          end else begin
            phase_d = PH_RELEASED;
            deb_d   = '0;
          end
        end
        PH_HOLD: begin
          if (!down_i) begin
            phase_d = PH_RELEASED;
            deb_d   = '0;
          end
        end
        PH_RELEASED: begin
          if (!down_i) begin
            deb_d = deb_inc;
            if (deb_inc >= debounce_ticks_i) begin
              phase_d   = PH_IDLE;
              pressed_d = 1'b0;
              evt_d     = EV_RELEASE;
              deb_d     = '0;
              hold_d    = '0;
            end
          end else begin
            phase_d = PH_CONFIRMED;
            deb_d   = '0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (down_i) begin
            phase_d = PH_PRESSED;
            deb_d   = '0;
          end
        end
      endcase
    end
    if (cmd_i.clear) begin
      evt_d = EV_NONE;
    end
  end

  assign status_o.evt          = evt_q;
  assign status_o.pressed_next = pressed_d;

endmodule

>>> hw/rtl/kdhd_merge.sv
// Action decode, addressed-key selection and the registered result stage.
module kdhd_merge #(
  parameter int unsigned NUM_KEYS = kdhd_pkg::NUM_KEYS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     action_i,
  input  logic [kdhd_pkg::KIDX_W-1:0]    key_index_i,
  input  logic [1:0]                     expected_event_i,
  input  kdhd_pkg::lane_status_t         status_i [NUM_KEYS],
  output kdhd_pkg::lane_cmd_t            cmd_o [NUM_KEYS],
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           matched_o,
  output logic [1:0]                     event_code_o,
  output logic [kdhd_pkg::PIN_W-1:0]     pressed_mask_o
);
  import kdhd_pkg::*;

  logic             accept;
  logic             key_ok;
  event_e           cur_evt;
  logic             hit;
  logic             matched_d;
  event_e           code_d;
  logic [PIN_W-1:0] mask_d;
  logic             valid_q;
  logic             matched_q;
  event_e           code_q;
  logic [PIN_W-1:0] mask_q;
  action_e          act;

  assign act        = action_e'(action_i);
  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign key_ok     = int'(key_index_i) < int'(NUM_KEYS);

  always_comb begin
    cur_evt = EV_NONE;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (int'(key_index_i) == k) begin
        cur_evt = status_i[k].evt;
      end
    end
    hit = key_ok && (act == ACT_TEST) && (expected_event_i != EV_NONE) &&
          (cur_evt == event_e'(expected_event_i));
    matched_d = hit;
    code_d    = EV_NONE;
    if (key_ok && (act == ACT_TEST || act == ACT_PEEK || act == ACT_CLR_KEY)) begin
      code_d = cur_evt;
    end
    mask_d = '0;
    for (int k = 0; k < PIN_W && k < NUM_KEYS; k++) begin
      mask_d[k] = status_i[k].pressed_next;
    end
    for (int k = 0; k < NUM_KEYS; k++) begin
      cmd_o[k].tick  = accept && (act == ACT_SCAN);
      cmd_o[k].clear = accept && ((act == ACT_CLR_ALL) ||
                       ((int'(key_index_i) == k) && ((act == ACT_CLR_KEY) || hit)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      matched_q <= matched_d;
      code_q    <= code_d;
      mask_q    <= mask_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign matched_o      = matched_q;
  assign event_code_o   = code_q;
  assign pressed_mask_o = mask_q;

endmodule

>>> hw/rtl/key_debounce_hold_detector.sv
// Top level of the key debounce and hold detector: config registers, key lanes, merge stage.
// A result is registered when its transaction is accepted and is shown from the next cycle on.
// Throughput: one transaction per cycle while the held result is taken; the output register is the only stage.
// Each key lane updates its state when a scan is accepted, so the next transaction needs no wait.
// Reset: all keys idle with counters cleared, no latched events, no pressed flags,
// debounce_ticks 5 and hold_ticks 100; the block is ready right after reset.
module key_debounce_hold_detector #(
  parameter int unsigned NUM_KEYS = kdhd_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kdhd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kdhd_pkg::CNT_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        action_i,
  input  logic [kdhd_pkg::PIN_W-1:0]        pin_levels_i,
  input  logic [kdhd_pkg::KIDX_W-1:0]       key_index_i,
  input  logic [1:0]                        expected_event_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              matched_o,
  output logic [1:0]                        event_code_o,
  output logic [kdhd_pkg::PIN_W-1:0]        pressed_mask_o
);
  import kdhd_pkg::*;

  logic [CNT_W-1:0] debounce_ticks_q;
  logic [CNT_W-1:0] hold_ticks_q;
  lane_status_t     status [NUM_KEYS];
  lane_cmd_t        cmd [NUM_KEYS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DEBOUNCE_RST;
      hold_ticks_q     <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DEBOUNCE: debounce_ticks_q <= cfg_data_i;
        CFG_HOLD:     hold_ticks_q     <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic down;
    if (k < PIN_W) begin : g_pin
      assign down = !pin_levels_i[k];
    end else begin : g_nopin
      assign down = 1'b0;
    end
    kdhd_lane u_lane (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .cmd_i            (cmd[k]),
      .down_i           (down),
      .debounce_ticks_i (debounce_ticks_q),
      .hold_ticks_i     (hold_ticks_q),
      .status_o         (status[k])
    );
  end

  kdhd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .key_index_i      (key_index_i),
    .expected_event_i (expected_event_i),
    .status_i         (status),
    .cmd_o            (cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .matched_o        (matched_o),
    .event_code_o     (event_code_o),
    .pressed_mask_o   (pressed_mask_o)
  );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the key debounce and hold detector, with its own key status predictor.
module tb_top;
  import kdhd_pkg::*;

  localparam int KEYS            = NUM_KEYS_DEF;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [2:0]       ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]       ACT_UNUSED_LAST  = 3'd7;
  localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};

  typedef struct packed {
    logic             matched;
    logic [1:0]       code;
    logic [PIN_W-1:0] mask;
  } key_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CNT_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [2:0]          action_i;
  logic [PIN_W-1:0]    pin_levels_i;
  logic [KIDX_W-1:0]   key_index_i;
  logic [1:0]          expected_event_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                matched_o;
  logic [1:0]          event_code_o;
  logic [PIN_W-1:0]    pressed_mask_o;

  bit               gaps_on;
  bit               stalls_on;
  bit               stall_request;
  logic [PIN_W-1:0] key_level;
  int               run_left [PIN_W];

  key_debounce_hold_detector #(
    .NUM_KEYS(KEYS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .pin_levels_i    (pin_levels_i),
    .key_index_i     (key_index_i),
    .expected_event_i(expected_event_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .matched_o       (matched_o),
    .event_code_o    (event_code_o),
    .pressed_mask_o  (pressed_mask_o)
  );

  class key_status_board;
    key_phase_e       phase [KEYS];
    logic [CNT_W-1:0] debounce_cnt [KEYS];
    logic [CNT_W-1:0] hold_cnt [KEYS];
    event_e           latched [KEYS];
    logic             pressed [KEYS];
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] hold_ticks;
    key_status_t      status_q [$];
    int               mismatches;

    function new();
      debounce_ticks = DEBOUNCE_RST;
      hold_ticks     = HOLD_RST;
      mismatches     = 0;
      for (int k = 0; k < KEYS; k++) begin
        phase[k]        = PH_IDLE;
        debounce_cnt[k] = '0;
        hold_cnt[k]     = '0;
        latched[k]      = EV_NONE;
        pressed[k]      = 1'b0;
      end
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CNT_W-1:0] value);
      if (idx == CFG_DEBOUNCE) begin
        debounce_ticks = value;
      end else begin
        hold_ticks = value;
      end
    endfunction

    function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function void scan_key(int k, logic down);
      case (phase[k])
        PH_PRESSED: begin
          if (down) begin
            debounce_cnt[k] = count_up(debounce_cnt[k]);
            if (debounce_cnt[k] >= debounce_ticks) begin
              phase[k]    = PH_CONFIRMED;
              pressed[k]  = 1'b1;
              hold_cnt[k] = '0;
              latched[k]  = EV_CLICK;
            end
          end else begin
            phase[k]        = PH_IDLE;
            debounce_cnt[k] = '0;
          end
        end
        PH_CONFIRMED: begin
          if (down) begin
            hold_cnt[k] = count_up(hold_cnt[k]);
            if (hold_cnt[k] >= hold_ticks) begin
              phase[k]   = PH_HOLD;
              latched[k] = EV_HOLD;
            end
          end else begin
            phase[k]        = PH_RELEASED;
            debounce_cnt[k] = '0;
          end
        end
        PH_HOLD: begin
          if (!down) begin
            phase[k]        = PH_RELEASED;
            debounce_cnt[k] = '0;
          end
        end
        PH_RELEASED: begin
          if (!down) begin
            debounce_cnt[k] = count_up(debounce_cnt[k]);
            if (debounce_cnt[k] >= debounce_ticks) begin
              phase[k]        = PH_IDLE;
              pressed[k]      = 1'b0;
              latched[k]      = EV_RELEASE;
              debounce_cnt[k] = '0;
              hold_cnt[k]     = '0;
            end
          end else begin
            phase[k]        = PH_CONFIRMED;
            debounce_cnt[k] = '0;
          end
        end
        default: begin
          phase[k] = PH_IDLE;
          if (down) begin
            phase[k]        = PH_PRESSED;
            debounce_cnt[k] = '0;
          end
        end
      endcase
    endfunction

    function void apply_command(logic [2:0] act, logic [PIN_W-1:0] pins,
                                logic [KIDX_W-1:0] key, logic [1:0] wanted);
      key_status_t st;
      logic        key_ok;
      int          idx;
      st     = '0;
      idx    = int'(key);
      key_ok = (idx < KEYS);
      case (act)
        ACT_SCAN: begin
          for (int k = 0; k < KEYS; k++) begin
            if (k < PIN_W) begin
              scan_key(k, !pins[k]);
            end else begin
              scan_key(k, 1'b0);
            end
          end
        end
        ACT_TEST: begin
          if (key_ok) begin
            st.code = latched[idx];
            if (wanted != EV_NONE && latched[idx] == wanted) begin
              latched[idx] = EV_NONE;
              st.matched   = 1'b1;
            end
          end
        end
        ACT_PEEK: begin
          if (key_ok) begin
            st.code = latched[idx];
          end
        end
        ACT_CLR_KEY: begin
          if (key_ok) begin
            st.code      = latched[idx];
            latched[idx] = EV_NONE;
          end
        end
        ACT_CLR_ALL: begin
          for (int k = 0; k < KEYS; k++) begin
            latched[k] = EV_NONE;
          end
        end
        default: ;
      endcase
      for (int k = 0; k < KEYS && k < PIN_W; k++) begin
        st.mask[k] = pressed[k];
      end
      status_q.push_back(st);
    endfunction

    function void compare_status(logic matched, logic [1:0] code, logic [PIN_W-1:0] mask);
      key_status_t want;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result with no command pending: matched=%0b code=%0d mask=%b",
                   $time, matched, code, mask);
        end
      end else begin
        want = status_q.pop_front();
        if (matched !== want.matched || code !== want.code || mask !== want.mask) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: mismatch: exp matched=%0b code=%0d mask=%b, got %0b %0d %b",
                     $time, want.matched, want.code, want.mask, matched, code, mask);
          end
        end
      end
    endfunction
  endclass

  key_status_board board;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.compare_status(matched_o, event_code_o, pressed_mask_o);
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [PIN_W-1:0] pins,
                           input logic [KIDX_W-1:0] key, input logic [1:0] wanted);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    pin_levels_i     <= pins;
    key_index_i      <= key;
    expected_event_i <= wanted;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.apply_command(act, pins, key, wanted);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CNT_W-1:0] debounce, input logic [CNT_W-1:0] hold);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DEBOUNCE;
    cfg_data_i  <= debounce;
    @(posedge clk_i);
    cfg_index_i <= CFG_HOLD;
    cfg_data_i  <= hold;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(CFG_DEBOUNCE, debounce);
    board.write_reg(CFG_HOLD, hold);
  endtask

  // Each key follows its own press and release runs, with occasional single-tick bounces
  // and queries, clears and unused action codes mixed in.
  task automatic scan_mix(input int count, input int span, input int squeeze_at);
    logic [2:0]        act;
    logic [PIN_W-1:0]  pins;
    logic [KIDX_W-1:0] key;
    int                pick;
    for (int i = 0; i < count; i++) begin
      if (i == squeeze_at) stall_request = 1'b1;
      pick = $urandom_range(0, 99);
      pins = PIN_W'($urandom());
      if ($urandom_range(0, 4) == 0) begin
        key = KIDX_W'($urandom_range(0, 7));
      end else begin
        key = KIDX_W'($urandom_range(0, KEYS - 1));
      end
      if (pick < 68) begin
        act = ACT_SCAN;
        for (int k = 0; k < PIN_W; k++) begin
          if (run_left[k] == 0) begin
            key_level[k] = ~key_level[k];
            run_left[k]  = $urandom_range(1, span);
          end
          run_left[k]--;
        end
        pins = key_level;
        if ($urandom_range(0, 11) == 0) pins[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
      end else if (pick < 78) act = ACT_TEST;
      else if (pick < 86) act = ACT_PEEK;
      else if (pick < 92) act = ACT_CLR_KEY;
      else if (pick < 96) act = ACT_CLR_ALL;
      else act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      send_item(act, pins, key, 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] debounce, input logic [CNT_W-1:0] hold,
                           input int count, input int squeeze_at);
    int span;
    settle();
    configure(debounce, hold);
    span = int'(debounce) + int'(hold) + 4;
    if (span > 44) span = 44;
    scan_mix(count, span, squeeze_at);
  endtask

  initial begin : result_sink
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready_i <= 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge clk_i);
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (stalls_on ? $urandom_range(1, 30) : 1) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("key_debounce_hold_detector test failed");
    $finish;
  end

  initial begin : stimulus
    board            = new();
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    stall_request    = 1'b0;
    key_level        = '1;
    for (int k = 0; k < PIN_W; k++) run_left[k] = 0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= CFG_DEBOUNCE;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    action_i         <= ACT_SCAN;
    pin_levels_i     <= '1;
    key_index_i      <= '0;
    expected_event_i <= EV_NONE;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(16'd1, 16'd1);
    send_item(ACT_PEEK, '1, 3'd0, EV_NONE);
    send_item(ACT_SCAN, 4'b0000, 3'd0, EV_NONE);
    send_item(ACT_SCAN, 4'b0000, 3'd0, EV_NONE);
    send_item(ACT_TEST, 4'b0000, 3'd0, EV_CLICK);
    send_item(ACT_SCAN, 4'b0000, 3'd0, EV_NONE);
    send_item(ACT_PEEK, 4'b0000, 3'd1, EV_NONE);
    send_item(ACT_TEST, 4'b0000, 3'd2, EV_NONE);
    send_item(ACT_TEST, 4'b0000, 3'd3, EV_CLICK);
    send_item(ACT_TEST, 4'b1111, 3'd7, EV_HOLD);
    send_item(ACT_CLR_KEY, 4'b1111, 3'd4, EV_RELEASE);
    send_item(ACT_CLR_KEY, 4'b0000, 3'd1, EV_NONE);
    send_item(ACT_SCAN, 4'b1010, 3'd0, EV_NONE);
    send_item(ACT_SCAN, 4'b1111, 3'd0, EV_NONE);
    send_item(ACT_TEST, 4'b1111, 3'd3, EV_RELEASE);
    send_item(ACT_SCAN, 4'b1010, 3'd0, EV_NONE);
    send_item(ACT_SCAN, 4'b1010, 3'd0, EV_NONE);
    send_item(ACT_UNUSED_LAST, 4'b1010, 3'd0, EV_HOLD);
    send_item(ACT_UNUSED_FIRST, 4'b0101, 3'd2, EV_CLICK);
    send_item(ACT_CLR_ALL, 4'b1010, 3'd5, EV_RELEASE);
    send_item(ACT_PEEK, 4'b1010, 3'd2, EV_NONE);
    send_item(ACT_SCAN, 4'b1110, 3'd6, EV_NONE);
    send_item(ACT_SCAN, 4'b1111, 3'd0, EV_NONE);
    send_item(ACT_SCAN, 4'b0111, 3'd0, EV_NONE);
    send_item(ACT_SCAN, 4'b1111, 3'd0, EV_NONE);
    send_item(ACT_TEST, 4'b1111, 3'd0, EV_RELEASE);

    run_phase(16'd2, 16'd5, 300, 120);
    run_phase(16'd3, 16'd12, 300, -1);
    run_phase(16'd1, 16'd1, 150, -1);
    run_phase(16'd4, 16'd30, 250, -1);
    run_phase(16'd0, 16'd0, 120, -1);
    run_phase(CNT_MAX, CNT_MAX, 60, -1);
    run_phase(CNT_MAX, 16'd1, 40, -1);

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_phase(16'd2, 16'd3, 200, -1);
    settle();

    if (board.mismatches == 0 && board.status_q.size() == 0) begin
      $display("key_debounce_hold_detector test passed");
    end else begin
      $display("key_debounce_hold_detector test failed");
    end
    $finish;
  end

endmodule
